FILE: rtl/dta_pkg.sv
// ----------------------------------------------------------------------------
// dta_pkg: shared types and constants
// Controller states, command and status structs, defaults for the tracker.
// ----------------------------------------------------------------------------
package dta_pkg;

  localparam int MaxTracks = 32;
  localparam int NumLabels = 10;
  localparam int CoordBits = 12;

  localparam logic [1:0] ModeBegin  = 2'd0;
  localparam logic [1:0] ModeDetect = 2'd1;
  localparam logic [1:0] ModeEnd    = 2'd2;

  localparam logic [1:0] RegHold    = 2'd0;
  localparam logic [1:0] RegDist    = 2'd1;
  localparam logic [1:0] RegConfirm = 2'd2;

  localparam logic [3:0] HoldReset    = 4'd5;
  localparam logic [11:0] DistReset   = 12'd15;
  localparam logic [7:0] ConfirmReset = 8'd4;
  localparam logic [7:0] HitsMax      = 8'd255;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AGE_RD,
    ST_AGE,
    ST_DET_RD,
    ST_DET,
    ST_LAB_RD,
    ST_LAB,
    ST_OUT_RD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic begin_op;
    logic first_op;
    logic age_rd;
    logic age_do;
    logic det_rd;
    logic det_do;
    logic lab_rd;
    logic lab_do;
    logic out_rd;
    logic out_do;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic det_hit;
    logic list_done;
  } sts_t;

endpackage

FILE: rtl/dta_ctrl.sv
// ----------------------------------------------------------------------------
// dta_ctrl: sequencing controller
// Steps through the aging, match, label and list passes of the datapath.
// ----------------------------------------------------------------------------
module dta_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [1:0]     mode,
  input  logic           first_frame,
  input  dta_pkg::sts_t  sts,
  output dta_pkg::cmd_t  cmd,
  output logic           busy
);

  dta_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= dta_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      dta_pkg::ST_IDLE: begin
        if (start) begin
          case (mode)
            dta_pkg::ModeBegin:  state_next = first_frame ? dta_pkg::ST_IDLE
                                                          : dta_pkg::ST_AGE_RD;
            dta_pkg::ModeDetect: state_next = dta_pkg::ST_DET_RD;
            dta_pkg::ModeEnd:    state_next = dta_pkg::ST_LAB_RD;
            default:             state_next = dta_pkg::ST_IDLE;
          endcase
        end
      end
      dta_pkg::ST_AGE_RD: state_next = sts.scan_done ? dta_pkg::ST_IDLE : dta_pkg::ST_AGE;
      dta_pkg::ST_AGE:    state_next = dta_pkg::ST_AGE_RD;
      dta_pkg::ST_DET_RD: state_next = dta_pkg::ST_DET;
      dta_pkg::ST_DET:    state_next = (sts.det_hit || sts.scan_done) ? dta_pkg::ST_IDLE
                                                                      : dta_pkg::ST_DET;
      dta_pkg::ST_LAB_RD: state_next = sts.scan_done ? dta_pkg::ST_OUT_RD : dta_pkg::ST_LAB;
      dta_pkg::ST_LAB:    state_next = dta_pkg::ST_LAB_RD;
      dta_pkg::ST_OUT_RD: state_next = dta_pkg::ST_OUT;
      dta_pkg::ST_OUT:    state_next = sts.list_done ? dta_pkg::ST_IDLE : dta_pkg::ST_OUT_RD;
      default:            state_next = dta_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state != dta_pkg::ST_IDLE);
    case (state)
      dta_pkg::ST_IDLE: begin
        cmd.load     = start;
        cmd.begin_op = start && (mode == dta_pkg::ModeBegin);
        cmd.first_op = start && (mode == dta_pkg::ModeBegin) && first_frame;
      end
      dta_pkg::ST_AGE_RD: cmd.age_rd = 1'b1;
      dta_pkg::ST_AGE:    cmd.age_do = 1'b1;
      dta_pkg::ST_DET_RD: cmd.det_rd = 1'b1;
      dta_pkg::ST_DET:    cmd.det_do = 1'b1;
      dta_pkg::ST_LAB_RD: cmd.lab_rd = 1'b1;
      dta_pkg::ST_LAB:    cmd.lab_do = 1'b1;
      dta_pkg::ST_OUT_RD: cmd.out_rd = 1'b1;
      dta_pkg::ST_OUT:    cmd.out_do = 1'b1;
      default:            cmd = '0;
    endcase
  end

endmodule

FILE: rtl/dta_dpath.sv
// ----------------------------------------------------------------------------
// dta_dpath: track table datapath
// Track memories, scan pointer, centre compare, label allocator, result regs.
// ----------------------------------------------------------------------------
module dta_dpath #(
  parameter int MAX_TRACKS = dta_pkg::MaxTracks,
  parameter int NUM_LABELS = dta_pkg::NumLabels,
  parameter int COORD_BITS = dta_pkg::CoordBits
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dta_pkg::cmd_t         cmd,
  output dta_pkg::sts_t         sts,
  input  logic [3:0]            hold_frames,
  input  logic [11:0]           match_distance,
  input  logic [7:0]            confirm_hits,
  input  logic [COORD_BITS-1:0] box_x,
  input  logic [COORD_BITS-1:0] box_y,
  input  logic [COORD_BITS-1:0] box_w,
  input  logic [COORD_BITS-1:0] box_h,
  output logic                  done,
  output logic [COORD_BITS-1:0] track_x,
  output logic [COORD_BITS-1:0] track_y,
  output logic [COORD_BITS-1:0] track_w,
  output logic [COORD_BITS-1:0] track_h,
  output logic [3:0]            track_label,
  output logic [7:0]            track_hits,
  output logic [5:0]            track_total,
  output logic                  entry_valid,
  output logic                  overflow,
  output logic                  last
);

  localparam int IW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int CW = $clog2(MAX_TRACKS + 1);
  localparam int BW = 4 * COORD_BITS;
  localparam int EW = BW + 4 + 8 + 4;
  localparam int XW = COORD_BITS + 1;

  logic [EW-1:0] mem [MAX_TRACKS];
  logic [MAX_TRACKS-1:0] matched;
  logic [CW-1:0] count, aged, ptr;
  logic [NUM_LABELS-1:0] busy_lab;
  logic restart, dropped;
  logic mv_pend;
  logic [BW-1:0] det_box;
  logic [XW-1:0] det_cx, det_cy;

  logic [EW-1:0] rd;
  logic [IW-1:0] rd_addr;
  logic we;
  logic [IW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  logic [COORD_BITS-1:0] rx, ry, rw, rh;
  logic [3:0] rhold, rlab;
  logic [7:0] rhits;
  assign {rx, ry, rw, rh, rhold, rhits, rlab} = rd;

  logic [XW-1:0] tcx, tcy, dx, dy;
  logic hit_now, scan_end, lab_fire;
  logic [CW-1:0] last_idx;
  logic [3:0] free_lab;
  logic free_any;

  assign last_idx = count - CW'(1);
  assign tcx = XW'(rx) + ((XW'(rw) + XW'(1)) >> 1);
  assign tcy = XW'(ry) + ((XW'(rh) + XW'(1)) >> 1);
  assign dx  = (det_cx > tcx) ? det_cx - tcx : tcx - det_cx;
  assign dy  = (det_cy > tcy) ? det_cy - tcy : tcy - det_cy;
  assign hit_now = !matched[ptr[IW-1:0]] && (ptr < aged) && (ptr < count) && !restart
                   && ({3'b0, dx} <= (XW + 3)'(match_distance))
                   && ({3'b0, dy} <= (XW + 3)'(match_distance));

  always_comb begin
    free_lab = '0;
    free_any = 1'b0;
    for (int k = NUM_LABELS - 1; k >= 0; k--) begin
      if (!busy_lab[k]) begin
        free_lab = 4'(k + 1);
        free_any = 1'b1;
      end
    end
  end

  assign lab_fire = !restart && (rhits > confirm_hits) && (rlab == 4'd0) && free_any;

  always_comb begin
    scan_end = 1'b0;
    if (cmd.age_rd || cmd.lab_rd) scan_end = (ptr >= count);
    else if (cmd.det_do) scan_end = restart || (ptr >= aged) || (ptr >= count)
                                    || (ptr == CW'(MAX_TRACKS - 1));
  end
  assign sts.scan_done = scan_end;
  assign sts.det_hit   = hit_now;
  assign sts.list_done = (count == '0) || (ptr >= last_idx);

  always_comb begin
    rd_addr = ptr[IW-1:0];
    if (cmd.det_do && !hit_now) rd_addr = IW'(ptr + CW'(1));
    if (cmd.age_do && rhold <= 4'd1) rd_addr = last_idx[IW-1:0];
    if (cmd.age_rd && mv_pend) rd_addr = count[IW-1:0];
  end

  always_ff @(posedge clk) begin
    rd <= mem[rd_addr];
    if (we) mem[wr_addr] <= wr_data;
  end

  always_comb begin
    we = 1'b0;
    wr_addr = ptr[IW-1:0];
    wr_data = rd;
    if (cmd.age_do && rhold > 4'd1) begin
      we = 1'b1;
      wr_data = {rx, ry, rw, rh, rhold - 4'd1, rhits, rlab};
    end else if (cmd.age_rd && mv_pend) begin
      we = 1'b1;
      wr_data = rd;
    end else if (cmd.det_do && hit_now) begin
      we = 1'b1;
      wr_data = {det_box, hold_frames, (rhits == dta_pkg::HitsMax) ? rhits : rhits + 8'd1,
                 rlab};
    end else if (cmd.det_do && scan_end && count < CW'(MAX_TRACKS)) begin
      we = 1'b1;
      wr_addr = count[IW-1:0];
      wr_data = {det_box, hold_frames, 8'd0, 4'd0};
    end else if (cmd.lab_do && lab_fire) begin
      we = 1'b1;
      wr_data = {rx, ry, rw, rh, rhold, rhits, free_lab};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0; aged <= '0; ptr <= '0; matched <= '0; busy_lab <= '0;
      restart <= 1'b0; dropped <= 1'b0; done <= 1'b0; mv_pend <= 1'b0;
    end else begin
      done <= 1'b0;
      mv_pend <= cmd.age_do && (rhold <= 4'd1) && (ptr != last_idx);
      if (cmd.load) begin
        ptr <= '0;
        det_box <= {box_x, box_y, box_w, box_h};
        det_cx <= XW'(box_x) + ((XW'(box_w) + XW'(1)) >> 1);
        det_cy <= XW'(box_y) + ((XW'(box_h) + XW'(1)) >> 1);
        if (cmd.begin_op) begin
          matched <= '0; dropped <= 1'b0; restart <= cmd.first_op;
          if (cmd.first_op) begin
            count <= '0; aged <= '0; busy_lab <= '0;
          end
        end
      end
      if (cmd.age_rd && scan_end) aged <= count;
      if (cmd.age_do) begin
        if (rhold > 4'd1) ptr <= ptr + CW'(1);
        else begin
          if (rlab != 4'd0 && rlab <= 4'(NUM_LABELS))
            busy_lab[rlab - 4'd1] <= 1'b0;
          count <= last_idx;
          matched[ptr[IW-1:0]] <= matched[last_idx[IW-1:0]];
        end
      end
      if (cmd.det_do) begin
        if (hit_now) matched[ptr[IW-1:0]] <= 1'b1;
        else if (scan_end) begin
          if (count < CW'(MAX_TRACKS)) begin
            matched[count[IW-1:0]] <= 1'b0;
            count <= count + CW'(1);
          end else dropped <= 1'b1;
        end else ptr <= ptr + CW'(1);
      end
      if (cmd.lab_do) begin
        if (lab_fire) busy_lab[free_lab - 4'd1] <= 1'b1;
        ptr <= ptr + CW'(1);
      end
      if (cmd.lab_rd && scan_end) ptr <= '0;
      if (cmd.out_do) begin
        done <= 1'b1;
        entry_valid <= (count != '0);
        overflow <= dropped;
        last <= sts.list_done;
        track_total <= count;
        {track_x, track_y, track_w, track_h} <= (count != '0) ? rd[EW-1:16] : '0;
        track_hits  <= (count != '0) ? rhits : 8'd0;
        track_label <= (count != '0) ? rlab : 4'd0;
        ptr <= ptr + CW'(1);
        if (sts.list_done) begin
          matched <= '0; dropped <= 1'b0;
        end
      end
    end
  end

  a_count: assert property (@(posedge clk) disable iff (rst) count <= CW'(MAX_TRACKS))
    else $error("table count beyond depth");
  a_aged: assert property (@(posedge clk) disable iff (rst)
    cmd.det_do |-> aged <= count) else $error("aged count above table count");
  a_done: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.out_do)) else $error("result without list step");

endmodule

FILE: rtl/detection_track_association_unit.sv
// ----------------------------------------------------------------------------
// detection_track_association_unit: multi-target track table
// Greedy first-match association of detections to tracks by centre distance.
// ----------------------------------------------------------------------------
// Usage: present an item with start high while busy is low. Mode begin ages
// the table entry by entry or, with first_frame, clears it without leaving
// idle. A detection item scans old tracks through the single memory read
// port, one entry a cycle. An end item runs a labelling pass, then lists
// every track, each result marked by done for one cycle; an empty table gives
// one result with entry_valid low. Results cannot be stalled by the receiver.
// Registers are written through cfg_valid/cfg_ready, index and data; the user
// must write them only while the block is idle, which the block does not
// enforce. cfg_ready is always high. Reset empties the table, frees all
// labels and loads the register defaults. No clearing pass.
// ----------------------------------------------------------------------------
module detection_track_association_unit #(
  parameter int MAX_TRACKS = dta_pkg::MaxTracks,
  parameter int NUM_LABELS = dta_pkg::NumLabels,
  parameter int COORD_BITS = dta_pkg::CoordBits
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            mode,
  input  logic                  first_frame,
  input  logic [COORD_BITS-1:0] box_x,
  input  logic [COORD_BITS-1:0] box_y,
  input  logic [COORD_BITS-1:0] box_w,
  input  logic [COORD_BITS-1:0] box_h,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [11:0]           cfg_data,
  output logic                  done,
  output logic [COORD_BITS-1:0] track_x,
  output logic [COORD_BITS-1:0] track_y,
  output logic [COORD_BITS-1:0] track_w,
  output logic [COORD_BITS-1:0] track_h,
  output logic [3:0]            track_label,
  output logic [7:0]            track_hits,
  output logic [5:0]            track_total,
  output logic                  entry_valid,
  output logic                  overflow,
  output logic                  last
);

  dta_pkg::cmd_t cmd;
  dta_pkg::sts_t sts;
  logic [3:0]  hold_frames;
  logic [11:0] match_distance;
  logic [7:0]  confirm_hits;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_frames    <= dta_pkg::HoldReset;
      match_distance <= dta_pkg::DistReset;
      confirm_hits   <= dta_pkg::ConfirmReset;
    end else if (cfg_valid) begin
      case (cfg_index)
        dta_pkg::RegHold:    hold_frames    <= cfg_data[3:0];
        dta_pkg::RegDist:    match_distance <= cfg_data;
        dta_pkg::RegConfirm: confirm_hits   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  dta_ctrl u_ctrl (
    .clk, .rst, .start, .mode, .first_frame, .sts, .cmd, .busy
  );

  dta_dpath #(
    .MAX_TRACKS(MAX_TRACKS), .NUM_LABELS(NUM_LABELS), .COORD_BITS(COORD_BITS)
  ) u_dpath (
    .clk, .rst, .cmd, .sts, .hold_frames, .match_distance, .confirm_hits,
    .box_x, .box_y, .box_w, .box_h, .done, .track_x, .track_y, .track_w,
    .track_h, .track_label, .track_hits, .track_total, .entry_valid,
    .overflow, .last
  );

endmodule
